>>> rtl/qdd_pkg.sv
// Shared types and constants for the quadrature direction detector.
`default_nettype none
package qdd_pkg;

  localparam int unsigned TimerBitsDefault = 16;
  localparam int unsigned LimitBits        = 16;
  localparam int unsigned ConfirmBits      = 2;
  localparam int unsigned CfgIndexBits     = 2;
  localparam int unsigned CfgDataBits      = 16;

  localparam logic [LimitBits-1:0]   ShortTimeoutReset = 16'd4;
  localparam logic [LimitBits-1:0]   LongTimeoutReset  = 16'd400;
  localparam logic [ConfirmBits-1:0] ConfirmsReset     = 2'd2;
  localparam logic [ConfirmBits-1:0] ConfirmsMax       = 2'd3;

  typedef enum logic [CfgIndexBits-1:0] {
    CFG_SHORT_TIMEOUT = 2'd0,
    CFG_LONG_TIMEOUT  = 2'd1,
    CFG_FWD_CONFIRMS  = 2'd2
  } cfg_index_e;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_REV_LOW = 3'd1,
    PH_REV_B   = 3'd2,
    PH_FWD_LOW = 3'd3,
    PH_FWD_A   = 3'd4
  } phase_e;

  typedef struct packed {
    logic a_level;
    logic b_level;
    logic enable;
  } in_item_t;

  typedef struct packed {
    logic direction_forward;
    logic ready_res;
    logic decided_now;
  } out_item_t;

  typedef struct packed {
    logic [LimitBits-1:0]   short_timeout_ticks;
    logic [LimitBits-1:0]   long_timeout_ticks;
    logic [ConfirmBits-1:0] forward_confirms;
  } cfg_t;

endpackage
`default_nettype wire

>>> rtl/quadrature_direction_detect.sv
// Quadrature direction detector top level: config registers, state and result register.
// An input transfer's result is registered into the output register in the cycle after it.
// Throughput: one sample per cycle while the output is not stalled; the detector state updates in a single pass.
// The output register frees as its result transfers, so input and output may move together.
// Reset: phase idle, timer, confirm count, direction and ready flags cleared;
// config registers return to their defaults and the output register empties.
`default_nettype none
module quadrature_direction_detect #(
  parameter int unsigned TIMER_BITS = qdd_pkg::TimerBitsDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  qdd_pkg::in_item_t                  in_item_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output qdd_pkg::out_item_t                 out_item_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [qdd_pkg::CfgIndexBits-1:0]   cfg_index_i,
  input  logic [qdd_pkg::CfgDataBits-1:0]    cfg_data_i
);

  qdd_pkg::cfg_t                   cfg_q;
  qdd_pkg::phase_e                 phase_q, phase_d;
  logic [TIMER_BITS-1:0]           elapsed_q, elapsed_d;
  logic [qdd_pkg::ConfirmBits-1:0] fwd_count_q, fwd_count_d;
  logic                            direction_q, direction_d;
  logic                            ready_q, ready_d;
  qdd_pkg::out_item_t              result_q, result_d;
  logic                            out_valid_q;
  logic                            in_xfer;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_xfer     = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_timeout_ticks <= qdd_pkg::ShortTimeoutReset;
      cfg_q.long_timeout_ticks  <= qdd_pkg::LongTimeoutReset;
      cfg_q.forward_confirms    <= qdd_pkg::ConfirmsReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        qdd_pkg::CFG_SHORT_TIMEOUT: cfg_q.short_timeout_ticks <= cfg_data_i;
        qdd_pkg::CFG_LONG_TIMEOUT:  cfg_q.long_timeout_ticks  <= cfg_data_i;
        qdd_pkg::CFG_FWD_CONFIRMS:
          cfg_q.forward_confirms <= cfg_data_i[qdd_pkg::ConfirmBits-1:0];
        default: ;
      endcase
    end
  end

  qdd_step #(
    .TIMER_BITS(TIMER_BITS)
  ) u_step (
    .phase_i     (phase_q),
    .elapsed_i   (elapsed_q),
    .fwd_count_i (fwd_count_q),
    .direction_i (direction_q),
    .ready_i     (ready_q),
    .cfg_i       (cfg_q),
    .item_i      (in_item_i),
    .phase_o     (phase_d),
    .elapsed_o   (elapsed_d),
    .fwd_count_o (fwd_count_d),
    .direction_o (direction_d),
    .ready_o     (ready_d),
    .result_o    (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= qdd_pkg::PH_IDLE;
      elapsed_q   <= '0;
      fwd_count_q <= '0;
      direction_q <= 1'b0;
      ready_q     <= 1'b0;
    end else if (in_xfer) begin
      phase_q     <= phase_d;
      elapsed_q   <= elapsed_d;
      fwd_count_q <= fwd_count_d;
      direction_q <= direction_d;
      ready_q     <= ready_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      result_q <= result_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/qdd_step.sv
// Next-state and result logic for one sample tick of the direction detector.
`default_nettype none
module qdd_step #(
  parameter int unsigned TIMER_BITS = qdd_pkg::TimerBitsDefault
) (
  input  qdd_pkg::phase_e                     phase_i,
  input  logic [TIMER_BITS-1:0]               elapsed_i,
  input  logic [qdd_pkg::ConfirmBits-1:0]     fwd_count_i,
  input  logic                                direction_i,
  input  logic                                ready_i,
  input  qdd_pkg::cfg_t                       cfg_i,
  input  qdd_pkg::in_item_t                   item_i,
  output qdd_pkg::phase_e                     phase_o,
  output logic [TIMER_BITS-1:0]               elapsed_o,
  output logic [qdd_pkg::ConfirmBits-1:0]     fwd_count_o,
  output logic                                direction_o,
  output logic                                ready_o,
  output qdd_pkg::out_item_t                  result_o
);

  localparam int unsigned CmpBits =
    (TIMER_BITS > qdd_pkg::LimitBits) ? TIMER_BITS : qdd_pkg::LimitBits;

  logic                                a_only;
  logic                                b_only;
  logic                                both_low;
  logic                                decided;
  logic [TIMER_BITS-1:0]               elapsed_inc;
  logic [qdd_pkg::LimitBits-1:0]       limit;
  logic                                timeout;
  logic [qdd_pkg::ConfirmBits-1:0]     fwd_inc;

  assign a_only   = item_i.a_level & ~item_i.b_level;
  assign b_only   = item_i.b_level & ~item_i.a_level;
  assign both_low = ~item_i.a_level & ~item_i.b_level;

  assign elapsed_inc = (elapsed_i == {TIMER_BITS{1'b1}}) ? elapsed_i
                                                         : elapsed_i + 1'b1;
  assign limit   = (phase_i == qdd_pkg::PH_REV_LOW) ? cfg_i.short_timeout_ticks
                                                    : cfg_i.long_timeout_ticks;
  assign timeout = CmpBits'(elapsed_inc) >= CmpBits'(limit);
  assign fwd_inc = (fwd_count_i == qdd_pkg::ConfirmsMax) ? fwd_count_i
                                                         : fwd_count_i + 1'b1;

  always_comb begin
    phase_o     = phase_i;
    elapsed_o   = elapsed_i;
    fwd_count_o = fwd_count_i;
    direction_o = direction_i;
    ready_o     = ready_i;
    decided     = 1'b0;
    if (!item_i.enable) begin
      phase_o   = qdd_pkg::PH_IDLE;
      elapsed_o = '0;
    end else begin
      unique case (phase_i)
        qdd_pkg::PH_REV_LOW, qdd_pkg::PH_REV_B, qdd_pkg::PH_FWD_A: begin
          if ((phase_i == qdd_pkg::PH_REV_LOW) && both_low) begin
            phase_o   = qdd_pkg::PH_REV_B;
            elapsed_o = '0;
          end else if ((phase_i == qdd_pkg::PH_REV_B) && b_only) begin
            direction_o = 1'b0;
            ready_o     = 1'b1;
            decided     = 1'b1;
            fwd_count_o = '0;
            phase_o     = qdd_pkg::PH_IDLE;
            elapsed_o   = '0;
          end else if ((phase_i == qdd_pkg::PH_FWD_A) && a_only) begin
            fwd_count_o = fwd_inc;
            if (fwd_inc >= cfg_i.forward_confirms) begin
              direction_o = 1'b1;
              ready_o     = 1'b1;
              decided     = 1'b1;
              fwd_count_o = '0;
            end
            phase_o   = qdd_pkg::PH_IDLE;
            elapsed_o = '0;
          end else if (timeout) begin
            phase_o   = qdd_pkg::PH_IDLE;
            elapsed_o = '0;
          end else begin
            elapsed_o = elapsed_inc;
          end
        end
        qdd_pkg::PH_FWD_LOW: begin
          if (both_low) begin
            phase_o   = qdd_pkg::PH_FWD_A;
            elapsed_o = '0;
          end
        end
        default: begin
          elapsed_o = '0;
          if (a_only) begin
            phase_o = qdd_pkg::PH_REV_LOW;
          end else if (b_only) begin
            phase_o = qdd_pkg::PH_FWD_LOW;
          end else begin
            phase_o = qdd_pkg::PH_IDLE;
          end
        end
      endcase
    end
  end

  assign result_o.direction_forward = direction_o;
  assign result_o.ready_res         = ready_o;
  assign result_o.decided_now       = decided;

endmodule
`default_nettype wire
